[rtl/pon_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Octave noise package
// Constants, register indexes and the shared lane control type of the octave noise pixel block.
// ----------------------------------------------------------------------------
package pon_pkg;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PERSISTENCE  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LACUNARITY   = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED         = 2'd3;

   localparam int unsigned OCTAVE_COUNT_BITS = 4;
   localparam int unsigned PERSIST_BITS      = 16;
   localparam int unsigned LACUN_BITS        = 16;
   localparam int unsigned SEED_BITS         = 32;
   localparam int unsigned GRAY_BITS         = 8;

   localparam logic [OCTAVE_COUNT_BITS-1:0] OCTAVE_COUNT_RESET = 4'd4;
   localparam logic [PERSIST_BITS-1:0]      PERSIST_RESET      = 16'd32768;
   localparam logic [LACUN_BITS-1:0]        LACUN_RESET        = 16'd512;
   localparam logic [SEED_BITS-1:0]         SEED_RESET         = 32'd0;

   localparam int unsigned LACUN_SHIFT = 8;
   localparam int unsigned AMP_SHIFT   = 16;
   localparam int unsigned AMP_BITS    = 17;
   localparam logic [AMP_BITS-1:0] AMP_ONE = 17'h10000;

   localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
   localparam logic [31:0] HASH_MUL_MIX = 32'd1597334677;
   localparam logic [31:0] HASH_MASK    = 32'h7FFFFFFF;

   localparam logic [1:0] GRAD_PX_PY = 2'd0;
   localparam logic [1:0] GRAD_NX_PY = 2'd1;
   localparam logic [1:0] GRAD_PX_NY = 2'd2;
   localparam logic [1:0] GRAD_NX_NY = 2'd3;

   localparam logic [GRAY_BITS-1:0] GRAY_MAX = 8'd255;

   typedef struct packed {
      logic adv;
      logic lane_en;
   } pon_lane_ctrl_type;

endpackage
`default_nettype wire

[rtl/pon_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel request channel
// Carries one pixel coordinate per transaction.
// ----------------------------------------------------------------------------
interface pon_req_if #(
   parameter int COORD_BITS = 12
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

[rtl/pon_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Gray level response channel
// Carries one noise pixel value per transaction.
// ----------------------------------------------------------------------------
interface pon_rsp_if;
   import pon_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [GRAY_BITS-1:0] gray_level;

   modport source (output valid, output gray_level, input ready);
   modport sink   (input valid, input gray_level, output ready);
endinterface
`default_nettype wire

[rtl/pon_octave.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Noise octave lane
// Eight-stage pipeline computing one weighted gradient noise octave.
// ----------------------------------------------------------------------------
module pon_octave #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                  clock,
   input  wire pon_pkg::pon_lane_ctrl_type            ctrl,
   input  wire logic [COORD_BITS-1:0]                 pixel_x,
   input  wire logic [COORD_BITS-1:0]                 pixel_y,
   input  wire logic [32+FRAC_BITS-1:0]               freq,
   input  wire logic [32+FRAC_BITS-1:0]               seed_off,
   input  wire logic [31:0]                           hash_seed,
   input  wire logic [pon_pkg::AMP_BITS-1:0]          amp,
   output logic signed [FRAC_BITS+3:0]                contrib
);
   import pon_pkg::*;

   localparam int CW = 32 + FRAC_BITS;
   localparam int MW = CW + COORD_BITS;
   localparam int NW = FRAC_BITS + 4;
   localparam int UW = FRAC_BITS + 1;
   localparam int PW = NW + AMP_BITS + 1;
   localparam logic signed [NW-1:0] FX_ONE = NW'(1) <<< FRAC_BITS;
   localparam logic [FRAC_BITS+1:0] FX_THREE = (FRAC_BITS+2)'(3) << FRAC_BITS;

   function automatic logic signed [NW-1:0] lerp_fx(input logic signed [NW-1:0] a,
                                                     input logic signed [NW-1:0] b,
                                                     input logic [UW-1:0] u);
      logic signed [NW:0]       diff;
      logic signed [NW+UW+1:0]  prod;
      logic signed [NW+UW+1:0]  shifted;
      diff = (NW+1)'(b) - (NW+1)'(a);
      prod = (NW+UW+2)'(diff) * (NW+UW+2)'($signed({1'b0, u}));
      shifted = prod >>> FRAC_BITS;
      return a + $signed(shifted[NW-1:0]);
   endfunction

   logic [CW-1:0]           fx_ff, fy_ff, fx_in, fy_in;
   logic [MW-1:0]           mul_x, mul_y;
   logic [31:0]             xa_ff, yb_ff, xa_in, yb_in;
   logic [FRAC_BITS-1:0]    sx2_ff, sy2_ff, sx3_ff, sy3_ff, sx4_ff, sy4_ff;
   logic [FRAC_BITS-1:0]    s2x_ff, s2y_ff, s2x_in, s2y_in;
   logic [2*FRAC_BITS-1:0]  sqx, sqy;
   logic [31:0]             t_ff [4];
   logic [31:0]             t_in [4];
   logic [31:0]             m_ff [4];
   logic [31:0]             m_in [4];
   logic [2*FRAC_BITS+1:0]  fprod_x, fprod_y;
   logic [UW-1:0]           ux3_ff, uy3_ff, ux4_ff, uy4_ff, ux5_ff, uy5_ff, uy6_ff;
   logic [UW-1:0]           ux_in, uy_in;
   logic signed [NW-1:0]    n_ff [4];
   logic signed [NW-1:0]    n_in [4];
   logic signed [NW-1:0]    l0_ff, l1_ff, nz_ff;
   logic signed [PW-1:0]    wprod;
   logic signed [PW-1:0]    wshift;
   logic signed [NW-1:0]    contrib_ff, contrib_in;

   always_comb begin
      mul_x = MW'(pixel_x) * MW'(freq);
      mul_y = MW'(pixel_y) * MW'(freq);
      fx_in = mul_x[CW-1:0] + seed_off;
      fy_in = mul_y[CW-1:0] + seed_off;
   end

   always_comb begin
      xa_in = fx_ff[CW-1:FRAC_BITS] * HASH_MUL_X;
      yb_in = fy_ff[CW-1:FRAC_BITS] * HASH_MUL_Y;
      sqx = (2*FRAC_BITS)'(fx_ff[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(fx_ff[FRAC_BITS-1:0]);
      sqy = (2*FRAC_BITS)'(fy_ff[FRAC_BITS-1:0]) * (2*FRAC_BITS)'(fy_ff[FRAC_BITS-1:0]);
      s2x_in = sqx[2*FRAC_BITS-1:FRAC_BITS];
      s2y_in = sqy[2*FRAC_BITS-1:FRAC_BITS];
   end

   always_comb begin
      logic [31:0] h;
      logic [31:0] xa;
      logic [31:0] yb;
      for (int c = 0; c < 4; c++) begin
         xa = c[0] ? xa_ff + HASH_MUL_X : xa_ff;
         yb = c[1] ? yb_ff + HASH_MUL_Y : yb_ff;
         h = (xa + yb + hash_seed) & HASH_MASK;
         t_in[c] = h ^ (h >> 13);
      end
      fprod_x = (2*FRAC_BITS+2)'(s2x_ff) *
                (2*FRAC_BITS+2)'(FX_THREE - {1'b0, sx2_ff, 1'b0});
      fprod_y = (2*FRAC_BITS+2)'(s2y_ff) *
                (2*FRAC_BITS+2)'(FX_THREE - {1'b0, sy2_ff, 1'b0});
      ux_in = fprod_x[2*FRAC_BITS:FRAC_BITS];
      uy_in = fprod_y[2*FRAC_BITS:FRAC_BITS];
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         m_in[c] = t_ff[c] * HASH_MUL_MIX;
      end
   end

   always_comb begin
      logic signed [NW-1:0] dx;
      logic signed [NW-1:0] dy;
      logic [1:0]           g;
      for (int c = 0; c < 4; c++) begin
         dx = $signed({4'b0000, sx4_ff});
         dy = $signed({4'b0000, sy4_ff});
         if (c[0]) begin
            dx = dx - FX_ONE;
         end
         if (c[1]) begin
            dy = dy - FX_ONE;
         end
         g = m_ff[c][1:0] ^ m_ff[c][17:16];
         unique case (g)
            GRAD_PX_PY: n_in[c] = dx + dy;
            GRAD_NX_PY: n_in[c] = dy - dx;
            GRAD_PX_NY: n_in[c] = dx - dy;
            GRAD_NX_NY: n_in[c] = -dx - dy;
            default:    n_in[c] = '0;
         endcase
      end
   end

   always_comb begin
      wprod = PW'(nz_ff) * PW'($signed({1'b0, amp}));
      wshift = wprod >>> AMP_SHIFT;
      contrib_in = ctrl.lane_en ? wshift[NW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         xa_ff <= xa_in;
         yb_ff <= yb_in;
         s2x_ff <= s2x_in;
         s2y_ff <= s2y_in;
         sx2_ff <= fx_ff[FRAC_BITS-1:0];
         sy2_ff <= fy_ff[FRAC_BITS-1:0];
         t_ff <= t_in;
         ux3_ff <= ux_in;
         uy3_ff <= uy_in;
         sx3_ff <= sx2_ff;
         sy3_ff <= sy2_ff;
         m_ff <= m_in;
         ux4_ff <= ux3_ff;
         uy4_ff <= uy3_ff;
         sx4_ff <= sx3_ff;
         sy4_ff <= sy3_ff;
         n_ff <= n_in;
         ux5_ff <= ux4_ff;
         uy5_ff <= uy4_ff;
         l0_ff <= lerp_fx(n_ff[0], n_ff[1], ux5_ff);
         l1_ff <= lerp_fx(n_ff[2], n_ff[3], ux5_ff);
         uy6_ff <= uy5_ff;
         nz_ff <= lerp_fx(l0_ff, l1_ff, uy6_ff);
         contrib_ff <= contrib_in;
      end
   end

   assign contrib = contrib_ff;

endmodule
`default_nettype wire

[rtl/perlin_octave_noise_pixel.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Octave noise pixel generator
// Streams one grayscale pixel of multi-octave gradient noise per transaction.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock cycle while the response side
// does not stall, and returns its gray level through one input register, an
// eight-stage lane per octave with all octaves side by side, one summing stage
// and one output register. A stalled response freezes the whole pipeline.
// After reset and after every register write the per-octave frequency and
// amplitude table is rebuilt one octave per cycle, so no pixel is taken until
// the settle counter has counted down to zero.
module perlin_octave_noise_pixel #(
   parameter int MAX_OCTAVES = 8,
   parameter int COORD_BITS  = 12,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   pon_req_if.sink                                   req_if,
   pon_rsp_if.source                                 rsp_if,
   input  wire logic                                 csr_wr_en,
   input  wire logic [pon_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [pon_pkg::CSR_DATA_BITS-1:0]    csr_wr_data
);
   import pon_pkg::*;

   localparam int CW  = 32 + FRAC_BITS;
   localparam int NW  = FRAC_BITS + 4;
   localparam int AW  = NW + $clog2(MAX_OCTAVES) + 1;
   localparam int GW  = AW + 10;
   localparam int LAT = 11;
   localparam int SCW = $clog2(MAX_OCTAVES + 1);
   localparam logic [SCW-1:0] SETTLE_CYCLES = SCW'(MAX_OCTAVES);
   localparam logic [CW-1:0] FREQ_ONE = CW'(1) << FRAC_BITS;
   localparam logic signed [GW-1:0] ACC_ONE = GW'(1) <<< FRAC_BITS;

   logic [OCTAVE_COUNT_BITS-1:0] octave_count_ff;
   logic [PERSIST_BITS-1:0]      persistence_ff;
   logic [LACUN_BITS-1:0]        lacunarity_ff;
   logic [SEED_BITS-1:0]         seed_ff;
   logic [SCW-1:0]               settle_ff, settle_in;
   logic                         adv;
   logic                         take;
   logic [LAT-1:0]               vld_ff, vld_in;
   logic [COORD_BITS-1:0]        px_ff, py_ff;
   logic [CW-1:0]                freq_w [MAX_OCTAVES];
   logic [AMP_BITS-1:0]          amp_w [MAX_OCTAVES];
   logic signed [NW-1:0]         contrib_w [MAX_OCTAVES];
   logic signed [AW-1:0]         acc_ff, acc_in;
   logic signed [GW-1:0]         biased, scaled, level;
   logic [GRAY_BITS-1:0]         gray_ff, gray_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCTAVE_COUNT_RESET;
         persistence_ff <= PERSIST_RESET;
         lacunarity_ff <= LACUN_RESET;
         seed_ff <= SEED_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_wr_data[OCTAVE_COUNT_BITS-1:0];
            CSR_PERSISTENCE:  persistence_ff <= csr_wr_data[PERSIST_BITS-1:0];
            CSR_LACUNARITY:   lacunarity_ff <= csr_wr_data[LACUN_BITS-1:0];
            CSR_SEED:         seed_ff <= csr_wr_data[SEED_BITS-1:0];
            default:          seed_ff <= seed_ff;
         endcase
      end
   end

   always_comb begin
      if (csr_wr_en) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - SCW'(1);
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_table
      if (k == 0) begin : g_first
         assign freq_w[k] = FREQ_ONE;
         assign amp_w[k] = AMP_ONE;
      end else begin : g_next
         logic [CW+LACUN_BITS-1:0]       fprod;
         logic [AMP_BITS+PERSIST_BITS-1:0] aprod;
         logic [CW-1:0]                  freq_ff;
         logic [AMP_BITS-1:0]            amp_ff;
         assign fprod = (CW+LACUN_BITS)'(freq_w[k-1]) * (CW+LACUN_BITS)'(lacunarity_ff);
         assign aprod = (AMP_BITS+PERSIST_BITS)'(amp_w[k-1]) *
                        (AMP_BITS+PERSIST_BITS)'(persistence_ff);
         always_ff @(posedge clock) begin
            freq_ff <= fprod[CW+LACUN_SHIFT-1:LACUN_SHIFT];
            amp_ff <= aprod[AMP_BITS+AMP_SHIFT-1:AMP_SHIFT];
         end
         assign freq_w[k] = freq_ff;
         assign amp_w[k] = amp_ff;
      end
   end

   assign adv = !vld_ff[LAT-1] || rsp_if.ready;
   assign take = adv && (settle_ff == '0);
   assign req_if.ready = take;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_if.valid && (settle_ff == '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= req_if.pixel_x;
         py_ff <= req_if.pixel_y;
      end
   end

   for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_lane
      pon_lane_ctrl_type lane_ctrl;
      assign lane_ctrl.adv = adv;
      assign lane_ctrl.lane_en = (k < int'(octave_count_ff));
      pon_octave #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS)
      ) u_octave (
         .clock     (clock),
         .ctrl      (lane_ctrl),
         .pixel_x   (px_ff),
         .pixel_y   (py_ff),
         .freq      (freq_w[k]),
         .seed_off  ({seed_ff, FRAC_BITS'(0)}),
         .hash_seed (seed_ff + 32'(k)),
         .amp       (amp_w[k]),
         .contrib   (contrib_w[k])
      );
   end

   always_comb begin
      acc_in = '0;
      for (int k = 0; k < MAX_OCTAVES; k++) begin
         acc_in = acc_in + AW'(contrib_w[k]);
      end
   end

   always_comb begin
      biased = GW'(acc_ff) + ACC_ONE;
      scaled = (biased <<< 8) - biased;
      level = scaled >>> (FRAC_BITS + 1);
      priority if (level < 0) begin
         gray_in = '0;
      end else if (level > GW'(GRAY_MAX)) begin
         gray_in = GRAY_MAX;
      end else begin
         gray_in = level[GRAY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_ff <= acc_in;
         gray_ff <= gray_in;
      end
   end

   assign rsp_if.valid = vld_ff[LAT-1];
   assign rsp_if.gray_level = gray_ff;

   a_write_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      $past(csr_wr_en) |-> !req_if.ready)
      else $error("pixel transaction taken while the octave table was rebuilding");

   a_sum_reaches_output: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LAT-2] && adv |=> rsp_if.valid)
      else $error("summed pixel did not reach the response register");

   a_reset_clears_output: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid after reset");

endmodule
`default_nettype wire

[dv/pon_checker.sv]
// ----------------------------------------------------------------------------
// Octave noise pixel checker
// Watches the pixel and gray level channels, predicts each gray level from
// the accepted pixel and the current register settings, and compares the
// responses in order.
// ----------------------------------------------------------------------------
module pon_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   pon_req_if.sink          req_mon,
   pon_rsp_if.sink          rsp_mon,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data,
   output int               fail_count,
   output int               gray_pending
);
   import pon_pkg::*;

   localparam int MAX_OCT = 8;
   localparam int FRAC = 16;
   localparam longint ONE = 64'sd65536;
   localparam longint unsigned CMASK = (64'd1 << 48) - 1;

   logic [3:0]  octaves_q;
   logic [15:0] persist_q;
   logic [15:0] lacun_q;
   logic [31:0] seed_q;
   logic [7:0]  gray_fifo[$];

   function automatic longint shr_fl(longint v, int n);
      return v >>> n;
   endfunction

   function automatic logic [31:0] lattice_hash(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] s);
      logic [31:0] h;
      h = (x * HASH_MUL_X + y * HASH_MUL_Y + s) & HASH_MASK;
      h = (h ^ (h >> 13)) * HASH_MUL_MIX;
      return h ^ (h >> 16);
   endfunction

   function automatic longint gradient(logic [31:0] h, longint dx, longint dy);
      case (h[1:0])
         GRAD_PX_PY: return dx + dy;
         GRAD_NX_PY: return -dx + dy;
         GRAD_PX_NY: return dx - dy;
         default:    return -dx - dy;
      endcase
   endfunction

   function automatic longint smooth(longint s);
      return shr_fl(shr_fl(s * s, FRAC) * (3 * ONE - 2 * s), FRAC);
   endfunction

   function automatic longint blend(longint a, longint b, longint t);
      return a + shr_fl(t * (b - a), FRAC);
   endfunction

   function automatic logic [7:0] predict_gray(logic [11:0] px, logic [11:0] py);
      longint unsigned freq, fx, fy, soff;
      longint amp, acc, sx, sy, u, v, n, g;
      logic [31:0] x0, y0, hs;
      int cnt;
      freq = 64'd65536;
      amp = 65536;
      acc = 0;
      soff = ({32'd0, seed_q} << FRAC) & CMASK;
      cnt = (octaves_q > MAX_OCT) ? MAX_OCT : octaves_q;
      for (int k = 0; k < cnt; k++) begin
         fx = (px * freq + soff) & CMASK;
         fy = (py * freq + soff) & CMASK;
         x0 = fx[47:16];
         y0 = fy[47:16];
         sx = fx[15:0];
         sy = fy[15:0];
         hs = seed_q + k;
         u = smooth(sx);
         v = smooth(sy);
         n = blend(blend(gradient(lattice_hash(x0, y0, hs), sx, sy),
                         gradient(lattice_hash(x0 + 1, y0, hs), sx - ONE, sy), u),
                   blend(gradient(lattice_hash(x0, y0 + 1, hs), sx, sy - ONE),
                         gradient(lattice_hash(x0 + 1, y0 + 1, hs), sx - ONE,
                                  sy - ONE), u), v);
         acc += shr_fl(n * amp, 16);
         freq = ((freq * lacun_q) >> 8) & CMASK;
         amp = (amp * persist_q) >> 16;
      end
      g = shr_fl((acc + ONE) * 255, FRAC + 1);
      if (g < 0) g = 0;
      if (g > 255) g = 255;
      return g[7:0];
   endfunction

   assign gray_pending = gray_fifo.size();

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         octaves_q <= OCTAVE_COUNT_RESET;
         persist_q <= PERSIST_RESET;
         lacun_q <= LACUN_RESET;
         seed_q <= SEED_RESET;
         fail_count <= 0;
         gray_fifo.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (gray_fifo.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("Unexpected gray level transaction %0d", rsp_mon.gray_level);
            end else begin
               want = gray_fifo.pop_front();
               if (want !== rsp_mon.gray_level) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("Gray level mismatch: expected %0d, got %0d",
                              want, rsp_mon.gray_level);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            gray_fifo.push_back(predict_gray(req_mon.pixel_x, req_mon.pixel_y));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_OCTAVE_COUNT: octaves_q <= csr_wr_data[3:0];
               CSR_PERSISTENCE:  persist_q <= csr_wr_data[15:0];
               CSR_LACUNARITY:   lacun_q <= csr_wr_data[15:0];
               default:          seed_q <= csr_wr_data;
            endcase
         end
      end
   end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// Octave noise pixel testbench
// Drives pixel transactions under several register settings with random
// gaps and stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import pon_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_OCTAVE_COUNT;
   logic [31:0] csr_wr_data = '0;
   int          fail_count;
   int          gray_pending;
   int          idle_cycles = 0;
   int          src_idle_pct = 0;
   int          snk_idle_pct = 0;
   bit          hold_rsp = 1'b0;
   int          pixel_count = 0;
   int          phase_count = 0;

   pon_req_if req_bus ();
   pon_rsp_if rsp_bus ();

   perlin_octave_noise_pixel i_dut (
      .clock(clock), .reset(reset), .req_if(req_bus.sink), .rsp_if(rsp_bus.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   pon_checker i_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus.sink), .rsp_mon(rsp_bus.sink),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .gray_pending(gray_pending)
   );

   always #2 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pixel_x = '0;
      req_bus.pixel_y = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || hold_rsp)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_pixel(logic [11:0] px, logic [11:0] py);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.pixel_x <= px;
      req_bus.pixel_y <= py;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pixel_count++;
   endtask

   task automatic drain;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (gray_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_regs(logic [3:0] oc, logic [15:0] pe, logic [15:0] la,
                           logic [31:0] sd);
      drain();
      write_csr(CSR_OCTAVE_COUNT, 32'(oc));
      write_csr(CSR_PERSISTENCE, 32'(pe));
      write_csr(CSR_LACUNARITY, 32'(la));
      write_csr(CSR_SEED, sd);
      phase_count++;
   endtask

   task automatic random_pixels(int n);
      for (int i = 0; i < n; i++)
         send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      src_idle_pct = 8;
      snk_idle_pct = 45;
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd0, 12'd4095);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'haaa, 12'h555);
      send_pixel(12'h555, 12'haaa);
      set_regs(4'd0, 16'd0, 16'd0, 32'd0);
      send_pixel(12'd17, 12'd99);
      send_pixel(12'd4095, 12'd1);
      set_regs(4'd15, 16'hffff, 16'hffff, 32'h7fffffff);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd1, 12'd2);
      send_pixel(12'd0, 12'd0);
      set_regs(4'd8, 16'hffff, 16'd256, 32'h80000000);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd3, 12'd3000);
      set_regs(4'd1, 16'd0, 16'hffff, 32'hffffffff);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      set_regs(4'd9, 16'h8000, 16'd512, 32'd12345);
      send_pixel(12'd100, 12'd200);
      send_pixel(12'd4000, 12'd17);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         random_pixels(40);
      join
      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin
            src_idle_pct = 45;
            snk_idle_pct = 8;
         end
         if (p == 8) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         set_regs(4'($urandom_range(15)), 16'($urandom), 16'($urandom), $urandom);
         random_pixels(58);
      end
      drain();
      $display("Covered %0d pixel transactions over %0d register settings,",
               pixel_count, phase_count);
      $display("including zero and saturated octave counts and a long response stall.");
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
